FILE: hw/rtl/plca_pkg.sv
// Shared types and constants for the pixel line charge accumulator.
// Used by the front end, the back end and the top level; depends on nothing.
package plca_pkg;

  localparam int unsigned LINE_WIDTH = 1024;
  localparam int unsigned ID_SLOTS   = 2;

  localparam int unsigned COL_W  = 10;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned ID_W   = 32;
  localparam int unsigned SLOT_W = 4;

  localparam int unsigned ADDR_W     = (LINE_WIDTH > 1) ? $clog2(LINE_WIDTH) : 1;
  localparam int unsigned CNT_W      = $clog2(LINE_WIDTH + 1);
  localparam int unsigned SLOT_IDX_W = (ID_SLOTS > 1) ? $clog2(ID_SLOTS) : 1;

  // The queue pointers wrap naturally, so the depth is kept a power of two.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // 1 eV in units of 0.1 eV.
  localparam logic signed [DATA_W-1:0] THRESHOLD = 32'sd10;

  typedef enum logic [1:0] {
    ACT_ADD   = 2'd0,
    ACT_CLEAR = 2'd1,
    ACT_READ  = 2'd2
  } action_e;

  typedef struct packed {
    action_e                    op;
    logic                       col_ok;
    logic [ADDR_W-1:0]          addr;
    logic signed [DATA_W-1:0]   signal;
    logic [ID_W-1:0]            photon_id;
    logic [ID_W-1:0]            source_id;
  } item_t;

  typedef struct packed {
    logic [ID_W-1:0] photon_id;
    logic [ID_W-1:0] source_id;
  } slot_t;

  typedef slot_t [ID_SLOTS-1:0] slot_row_t;

  localparam int unsigned ROW_W = ID_SLOTS * 2 * ID_W;

endpackage

FILE: hw/rtl/plca_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module plca_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/plca_front.sv
// Front end: accepts input items, classifies them and queues them for the back end.
// Depends on plca_pkg.
module plca_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    action_i,
  input  logic [plca_pkg::COL_W-1:0]    column_i,
  input  logic signed [plca_pkg::DATA_W-1:0] signal_i,
  input  logic [plca_pkg::ID_W-1:0]     photon_id_i,
  input  logic [plca_pkg::ID_W-1:0]     source_id_i,
  input  logic                          init_busy_i,
  output logic                          head_valid_o,
  output plca_pkg::item_t               head_o,
  input  logic                          pop_i
);

  plca_pkg::item_t                     q_mem_q [plca_pkg::QUEUE_DEPTH];
  logic [plca_pkg::QPTR_W-1:0]         wr_ptr_q, wr_ptr_d;
  logic [plca_pkg::QPTR_W-1:0]         rd_ptr_q, rd_ptr_d;
  logic [plca_pkg::QCNT_W-1:0]         count_q, count_d;
  plca_pkg::item_t                     item;
  logic                                meaningful;
  logic                                accept;
  logic                                push;
  logic                                pop;

  always_comb begin
    item.op        = plca_pkg::ACT_ADD;
    item.col_ok    = (32'(column_i) < 32'(plca_pkg::LINE_WIDTH));
    item.addr      = plca_pkg::ADDR_W'(column_i);
    item.signal    = signal_i;
    item.photon_id = photon_id_i;
    item.source_id = source_id_i;
    meaningful     = 1'b1;
    unique case (action_i)
      plca_pkg::ACT_ADD:   item.op = plca_pkg::ACT_ADD;
      plca_pkg::ACT_CLEAR: item.op = plca_pkg::ACT_CLEAR;
      plca_pkg::ACT_READ:  item.op = plca_pkg::ACT_READ;
      default:             meaningful = 1'b0;
    endcase
  end

  // Items are held off while the store is swept after reset and while the queue is full.
  assign in_stall_o   = init_busy_i || (count_q == plca_pkg::QCNT_W'(plca_pkg::QUEUE_DEPTH));
  assign accept       = in_valid_i && !in_stall_o;
  assign push         = accept && meaningful;
  assign head_valid_o = (count_q != '0);
  assign head_o       = q_mem_q[rd_ptr_q];
  assign pop          = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

FILE: hw/rtl/plca_back.sv
// Back end: executes queued items against the charge and ID slot memories and
// drives the result register. Depends on plca_pkg and plca_ram.
module plca_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               head_valid_i,
  input  plca_pkg::item_t                    head_i,
  output logic                               pop_o,
  output logic                               init_busy_o,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [plca_pkg::DATA_W-1:0] pixel_charge_o,
  output logic [plca_pkg::SLOT_W-1:0]        slot_index_o,
  output logic [plca_pkg::ID_W-1:0]          stored_photon_id_o,
  output logic [plca_pkg::ID_W-1:0]          stored_source_id_o,
  output logic                               line_has_charge_o,
  output logic                               last_o
);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_RDOUT,
    S_CLR,
    S_CLR_OUT
  } state_e;

  state_e                                state_q, state_d;
  logic [plca_pkg::CNT_W-1:0]            cnt_q, cnt_d;
  plca_pkg::item_t                       cur_q, cur_d;
  logic                                  flag_q, flag_d;
  logic [plca_pkg::SLOT_IDX_W-1:0]       slot_q, slot_d;
  plca_pkg::slot_row_t                   row_q, row_d;
  logic signed [plca_pkg::DATA_W-1:0]    chg_q, chg_d;

  logic                                  out_valid_q, out_valid_d;
  logic signed [plca_pkg::DATA_W-1:0]    out_charge_q, out_charge_d;
  logic [plca_pkg::SLOT_W-1:0]           out_slot_q, out_slot_d;
  logic [plca_pkg::ID_W-1:0]             out_photon_q, out_photon_d;
  logic [plca_pkg::ID_W-1:0]             out_source_q, out_source_d;
  logic                                  out_flag_q, out_flag_d;
  logic                                  out_last_q, out_last_d;

  logic                                  ram_we;
  logic [plca_pkg::ADDR_W-1:0]           ram_waddr;
  logic [plca_pkg::ADDR_W-1:0]           ram_raddr;
  logic signed [plca_pkg::DATA_W-1:0]    wr_charge;
  plca_pkg::slot_row_t                   wr_row;
  logic [plca_pkg::DATA_W-1:0]           rd_charge_raw;
  logic [plca_pkg::ROW_W-1:0]            rd_row_raw;
  logic signed [plca_pkg::DATA_W-1:0]    rd_charge;
  plca_pkg::slot_row_t                   rd_row;

  logic signed [plca_pkg::DATA_W-1:0]    add_sig;
  logic signed [plca_pkg::DATA_W:0]      add_sum;
  logic signed [plca_pkg::DATA_W-1:0]    add_sat;
  plca_pkg::slot_row_t                   add_row;
  logic                                  slot_found;
  logic                                  out_load;

  plca_ram #(
    .WIDTH (plca_pkg::DATA_W),
    .DEPTH (plca_pkg::LINE_WIDTH)
  ) u_charge_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (wr_charge),
    .raddr_i (ram_raddr),
    .rdata_o (rd_charge_raw)
  );

  plca_ram #(
    .WIDTH (plca_pkg::ROW_W),
    .DEPTH (plca_pkg::LINE_WIDTH)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (wr_row),
    .raddr_i (ram_raddr),
    .rdata_o (rd_row_raw)
  );

  assign rd_charge = $signed(rd_charge_raw);
  assign rd_row    = rd_row_raw;

  // The read address is presented in the state before the one that uses the registered read data.
  always_comb begin
    unique case (state_q)
      S_IDLE:  ram_raddr = head_i.addr;
      S_CLR:   ram_raddr = cnt_q[plca_pkg::ADDR_W-1:0];
      default: ram_raddr = cur_q.addr;
    endcase
  end

  // Add datapath: saturating charge update and slot placement.
  always_comb begin
    add_sig = $signed(cur_q.signal);
    add_sum = {rd_charge[plca_pkg::DATA_W-1], rd_charge} + {add_sig[plca_pkg::DATA_W-1], add_sig};
    if (add_sum[plca_pkg::DATA_W] != add_sum[plca_pkg::DATA_W-1]) begin
      add_sat = add_sum[plca_pkg::DATA_W] ? {1'b1, {(plca_pkg::DATA_W-1){1'b0}}}
                                          : {1'b0, {(plca_pkg::DATA_W-1){1'b1}}};
    end else begin
      add_sat = add_sum[plca_pkg::DATA_W-1:0];
    end

    add_row    = rd_row;
    slot_found = 1'b0;
    if (rd_charge < plca_pkg::THRESHOLD) begin
      add_row[0].photon_id = cur_q.photon_id;
      add_row[0].source_id = cur_q.source_id;
    end else if (add_sig > plca_pkg::THRESHOLD) begin
      for (int k = 0; k < plca_pkg::ID_SLOTS; k++) begin
        if (!slot_found && (rd_row[k].photon_id == '0)) begin
          add_row[k].photon_id = cur_q.photon_id;
          add_row[k].source_id = cur_q.source_id;
          slot_found           = 1'b1;
        end
      end
    end
  end

  assign out_load = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    cur_d        = cur_q;
    flag_d       = flag_q;
    slot_d       = slot_q;
    row_d        = row_q;
    chg_d        = chg_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_charge_d = out_charge_q;
    out_slot_d   = out_slot_q;
    out_photon_d = out_photon_q;
    out_source_d = out_source_q;
    out_flag_d   = out_flag_q;
    out_last_d   = out_last_q;
    pop_o        = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = cur_q.addr;
    wr_charge    = '0;
    wr_row       = '0;

    unique case (state_q)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q[plca_pkg::ADDR_W-1:0];
        if (cnt_q == plca_pkg::CNT_W'(plca_pkg::LINE_WIDTH - 1)) begin
          cnt_d   = '0;
          state_d = S_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      S_IDLE: begin
        if (head_valid_i) begin
          pop_o = 1'b1;
          cur_d = head_i;
          if (head_i.op == plca_pkg::ACT_CLEAR) begin
            cnt_d   = '0;
            state_d = flag_q ? S_CLR : S_CLR_OUT;
          end else begin
            state_d = S_EXEC;
          end
        end
      end

      S_EXEC: begin
        if (cur_q.op == plca_pkg::ACT_ADD) begin
          if (out_load) begin
            out_valid_d  = 1'b1;
            out_slot_d   = '0;
            out_last_d   = 1'b1;
            if (cur_q.col_ok) begin
              ram_we       = 1'b1;
              wr_charge    = add_sat;
              wr_row       = add_row;
              flag_d       = 1'b1;
              out_charge_d = add_sat;
              out_photon_d = add_row[0].photon_id;
              out_source_d = add_row[0].source_id;
              out_flag_d   = 1'b1;
            end else begin
              out_charge_d = '0;
              out_photon_d = '0;
              out_source_d = '0;
              out_flag_d   = flag_q;
            end
            state_d = S_IDLE;
          end
        end else begin
          chg_d   = cur_q.col_ok ? rd_charge : '0;
          row_d   = cur_q.col_ok ? rd_row : '0;
          slot_d  = '0;
          state_d = S_RDOUT;
        end
      end

      S_RDOUT: begin
        if (out_load) begin
          out_valid_d  = 1'b1;
          out_charge_d = chg_q;
          out_slot_d   = plca_pkg::SLOT_W'(slot_q);
          out_photon_d = row_q[slot_q].photon_id;
          out_source_d = row_q[slot_q].source_id;
          out_flag_d   = flag_q;
          out_last_d   = (slot_q == plca_pkg::SLOT_IDX_W'(plca_pkg::ID_SLOTS - 1));
          if (out_last_d) begin
            state_d = S_IDLE;
          end else begin
            slot_d = slot_q + 1'b1;
          end
        end
      end

      S_CLR: begin
        // Data read for the previous count arrives now; wipe that column if its charge is positive.
        if ((cnt_q != '0) && (rd_charge > 0)) begin
          ram_we    = 1'b1;
          ram_waddr = plca_pkg::ADDR_W'(cnt_q - 1'b1);
        end
        if (cnt_q == plca_pkg::CNT_W'(plca_pkg::LINE_WIDTH)) begin
          flag_d  = 1'b0;
          state_d = S_CLR_OUT;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      S_CLR_OUT: begin
        if (out_load) begin
          out_valid_d  = 1'b1;
          out_charge_d = '0;
          out_slot_d   = '0;
          out_photon_d = '0;
          out_source_d = '0;
          out_flag_d   = 1'b0;
          out_last_d   = 1'b1;
          state_d      = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      cnt_q       <= '0;
      flag_q      <= 1'b0;
      slot_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      flag_q      <= flag_d;
      slot_q      <= slot_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q        <= cur_d;
    row_q        <= row_d;
    chg_q        <= chg_d;
    out_charge_q <= out_charge_d;
    out_slot_q   <= out_slot_d;
    out_photon_q <= out_photon_d;
    out_source_q <= out_source_d;
    out_flag_q   <= out_flag_d;
    out_last_q   <= out_last_d;
  end

  assign init_busy_o        = (state_q == S_INIT);
  assign out_valid_o        = out_valid_q;
  assign pixel_charge_o     = out_charge_q;
  assign slot_index_o       = out_slot_q;
  assign stored_photon_id_o = out_photon_q;
  assign stored_source_id_o = out_source_q;
  assign line_has_charge_o  = out_flag_q;
  assign last_o             = out_last_q;

  a_no_pop_in_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INIT) |-> !pop_o)
    else $error("item taken from the queue during the reset sweep");

  a_no_write_in_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !ram_we)
    else $error("memory written while idle");

  a_slot_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RDOUT) |-> (32'(slot_q) < plca_pkg::ID_SLOTS))
    else $error("slot counter beyond the last slot");

  a_flag_falls_on_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(flag_q) |-> ($past(state_q) == S_CLR))
    else $error("charge flag lowered outside a line clear");

endmodule

FILE: hw/rtl/pixel_line_charge_accumulator_top.sv
// Top level of the pixel line charge accumulator: front end, queue and back end.
// Depends on plca_pkg, plca_front and plca_back (which holds the plca_ram instances).
//
// Timing: after reset the block sweeps the charge and ID slot memories to zero, one
// column per cycle, with in_stall_o high. A two-entry queue sits between the input
// and the execution unit. An add to a column within the line does one
// read-modify-write on the column memories, whose read port is registered; a read
// returns one result per slot, a clear while the line holds charge walks every column
// at one per cycle, and a clear of an empty line skips the walk. A held result stalls
// only the execution unit; the queue keeps taking items until it is full.
module pixel_line_charge_accumulator_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [1:0]                         action_i,
  input  logic [plca_pkg::COL_W-1:0]         column_i,
  input  logic signed [plca_pkg::DATA_W-1:0] signal_i,
  input  logic [plca_pkg::ID_W-1:0]          photon_id_i,
  input  logic [plca_pkg::ID_W-1:0]          source_id_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [plca_pkg::DATA_W-1:0] pixel_charge_o,
  output logic [plca_pkg::SLOT_W-1:0]        slot_index_o,
  output logic [plca_pkg::ID_W-1:0]          stored_photon_id_o,
  output logic [plca_pkg::ID_W-1:0]          stored_source_id_o,
  output logic                               line_has_charge_o,
  output logic                               last_o
);

  logic            head_valid;
  plca_pkg::item_t head;
  logic            pop;
  logic            init_busy;

  plca_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .action_i     (action_i),
    .column_i     (column_i),
    .signal_i     (signal_i),
    .photon_id_i  (photon_id_i),
    .source_id_i  (source_id_i),
    .init_busy_i  (init_busy),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  plca_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .head_valid_i       (head_valid),
    .head_i             (head),
    .pop_o              (pop),
    .init_busy_o        (init_busy),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .pixel_charge_o     (pixel_charge_o),
    .slot_index_o       (slot_index_o),
    .stored_photon_id_o (stored_photon_id_o),
    .stored_source_id_o (stored_source_id_o),
    .line_has_charge_o  (line_has_charge_o),
    .last_o             (last_o)
  );

endmodule
